### sv/vbe_pkg.sv
// shared types and character constants for the visible byte escaper
// no dependencies; imported by every module of the block
package vbe_pkg;

	// input byte codes
	localparam logic [7:0] BYTE_BS    = 8'h08;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_DEL   = 8'h7F;

	// output characters
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = "\\";
	localparam logic [7:0] CH_CARET  = "^";
	localparam logic [7:0] CH_AT     = "@";
	localparam logic [7:0] CH_QMARK  = "?";
	localparam logic [7:0] CH_ZERO   = "0";
	localparam logic [7:0] CH_LS     = "s";
	localparam logic [7:0] CH_UE     = "E";
	localparam logic [7:0] CH_LB     = "b";
	localparam logic [7:0] CH_LR     = "r";
	localparam logic [7:0] CH_LN     = "n";
	localparam logic [7:0] CH_LT     = "t";

	// configuration register indexes
	localparam logic [1:0] REG_CUT       = 2'd0;
	localparam logic [1:0] REG_WRAP      = 2'd1;
	localparam logic [1:0] REG_ESC_WRAP  = 2'd2;

	localparam logic [6:0] WRAP_RESET     = 7'd70;
	localparam logic [6:0] ESC_WRAP_RESET = 7'd60;

	typedef struct packed {
		logic       cut;
		logic [6:0] wrap;
		logic [6:0] esc_wrap;
	} cfg_t;

	// classified item: up to four output characters plus flags
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            esc;
		logic            eos;
	} plan_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CHAR = 3'b010,
		ST_POST = 3'b100
	} st_t;

endpackage

### sv/vbe_front.sv
// front end: input handshake and byte classification into a character plan
// depends on vbe_pkg
module vbe_front (
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          cmd,
	input  logic [7:0]    data_byte,
	input  logic          q_full,
	output logic          push,
	output vbe_pkg::plan_t plan
);
	import vbe_pkg::*;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		plan.chars    = '0;
		plan.last_idx = 2'd1;
		plan.esc      = 1'b0;
		plan.eos      = cmd;
		plan.chars[0] = CH_BSLASH;
		priority if (cmd) begin
			plan.last_idx = 2'd0;
			plan.chars[0] = CH_NL;
		end else if (data_byte == BYTE_SPACE) begin
			plan.chars[1] = CH_LS;
		end else if (data_byte < BYTE_SPACE) begin
			priority if (data_byte == BYTE_ESC) begin
				plan.esc      = 1'b1;
				plan.chars[1] = CH_UE;
			end else if (data_byte == BYTE_BS) begin
				plan.chars[1] = CH_LB;
			end else if (data_byte == BYTE_CR) begin
				plan.chars[1] = CH_LR;
			end else if (data_byte == BYTE_LF) begin
				plan.chars[1] = CH_LN;
			end else if (data_byte == BYTE_TAB) begin
				plan.chars[1] = CH_LT;
			end else begin
				plan.chars[0] = CH_CARET;
				plan.chars[1] = CH_AT + data_byte;
			end
		end else if (data_byte < BYTE_DEL) begin
			if (data_byte == CH_BSLASH || data_byte == CH_CARET) begin
				plan.chars[1] = data_byte;
			end else begin
				plan.last_idx = 2'd0;
				plan.chars[0] = data_byte;
			end
		end else if (data_byte == BYTE_DEL) begin
			plan.chars[0] = CH_CARET;
			plan.chars[1] = CH_QMARK;
		end else begin
			// high byte as three octal digits
			plan.last_idx = 2'd3;
			plan.chars[1] = CH_ZERO + {6'd0, data_byte[7:6]};
			plan.chars[2] = CH_ZERO + {5'd0, data_byte[5:3]};
			plan.chars[3] = CH_ZERO + {5'd0, data_byte[2:0]};
		end
	end

endmodule

### sv/vbe_queue.sv
// short plan queue between front and back end, flops with one read port
// depends on vbe_pkg
module vbe_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vbe_pkg::plan_t wr_plan,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output vbe_pkg::plan_t head
);
	import vbe_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	plan_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_push_advances: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("push lost");

endmodule

### sv/vbe_back.sv
// back end: column tracking, wrap decisions, one character beat per cycle unless out_stall holds the output
// depends on vbe_pkg; takes plans from vbe_queue
module vbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  vbe_pkg::cfg_t  cfg,
	input  logic           head_valid,
	input  vbe_pkg::plan_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_char,
	output logic           last
);
	import vbe_pkg::*;

	st_t        st_q, st_d;
	plan_t      plan_q;
	logic [1:0] idx_q, idx_d;
	logic [7:0] col_q, col_d;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_q;

	logic       adv;
	logic       emit;
	logic [7:0] ch;
	logic       lst;
	logic       load;

	// character step for the current plan and index
	plan_t      src;
	logic [1:0] cur_idx;
	logic [7:0] col_inc;
	logic       fin;
	logic       over;

	assign adv     = !out_valid_q || !out_stall;
	assign src     = (st_q == ST_IDLE) ? head : plan_q;
	assign cur_idx = (st_q == ST_IDLE) ? 2'd0 : idx_q;
	assign col_inc = col_q + 8'd1;
	assign fin     = (cur_idx == src.last_idx);
	assign over    = (col_inc > {1'b0, cfg.wrap});

	always_comb begin
		emit  = 1'b0;
		ch    = CH_NL;
		lst   = 1'b0;
		load  = 1'b0;
		pop   = 1'b0;
		st_d  = st_q;
		idx_d = idx_q;
		col_d = col_q;
		unique case (st_q)
			ST_IDLE: begin
				if (head_valid && adv) begin
					pop  = 1'b1;
					emit = 1'b1;
					if (head.eos) begin
						lst   = 1'b1;
						col_d = '0;
					end else if (head.esc &&
							(cfg.cut || col_q > {1'b0, cfg.esc_wrap})) begin
						// newline ahead of the escape, chars follow
						load  = 1'b1;
						col_d = '0;
						idx_d = 2'd0;
						st_d  = ST_CHAR;
					end else begin
						load  = 1'b1;
						ch    = src.chars[cur_idx];
						col_d = col_inc;
						lst   = fin && !over;
						idx_d = cur_idx + 2'd1;
						st_d  = !fin ? ST_CHAR : (over ? ST_POST : ST_IDLE);
					end
				end
			end
			ST_CHAR: begin
				if (adv) begin
					emit  = 1'b1;
					ch    = src.chars[cur_idx];
					col_d = col_inc;
					lst   = fin && !over;
					idx_d = cur_idx + 2'd1;
					st_d  = !fin ? ST_CHAR : (over ? ST_POST : ST_IDLE);
				end
			end
			ST_POST: begin
				if (adv) begin
					emit  = 1'b1;
					lst   = 1'b1;
					col_d = '0;
					st_d  = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plan_q <= head;
		end
		if (adv && emit) begin
			out_char_q <= ch;
			last_q     <= lst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			col_q <= col_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	a_post_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_POST |-> out_valid_q && !last_q)
		else $error("wrap newline pending without a preceding beat");

	a_col_fits: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> !col_q[7])
		else $error("column above 127 between items");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> st_q == ST_IDLE)
		else $error("last beat shown while item still in progress");

	a_newline_clears_col: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && ch == CH_NL && st_q != ST_CHAR |=> col_q == '0)
		else $error("column not cleared by newline");

endmodule

### sv/visible_byte_escaper_core.sv
// first beat: item goes to the plan queue, then the single-beat output register
// throughput: one output beat per cycle unless out_stall holds it; an item
// yields 1 to 5 beats (5 for a high byte that also wraps)
// a 2-entry plan queue lets input be taken while the back end emits
// reset: column 0, wrap 70, escape wrap 60, cut mode off, queue and output empty
module visible_byte_escaper_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last
);
	import vbe_pkg::*;

	cfg_t  cfg_q;
	plan_t front_plan;
	plan_t head;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cut      <= 1'b0;
			cfg_q.wrap     <= WRAP_RESET;
			cfg_q.esc_wrap <= ESC_WRAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CUT:      cfg_q.cut      <= cfg_data[0];
				REG_WRAP:     cfg_q.wrap     <= cfg_data;
				REG_ESC_WRAP: cfg_q.esc_wrap <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vbe_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.plan      (front_plan)
	);

	vbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_plan    (front_plan),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	vbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.last       (last)
	);

endmodule
